/* rtl/fss_pkg.sv */
// Shared constants, register codes and helper functions of the fuzzy subsequence scorer.
// No dependencies. Imported by the channel interfaces, the top level and the checker.
package fss_pkg;

  localparam int unsigned CharW         = 8;
  localparam int unsigned MaxQueryChars = 32;
  localparam int unsigned QLenW         = $clog2(MaxQueryChars + 1);
  localparam int unsigned QIdxW         = $clog2(MaxQueryChars);
  localparam int unsigned NumQueryRegs  = 4;
  localparam int unsigned CharsPerReg   = 8;
  localparam int unsigned RegDataW      = 64;
  localparam int unsigned QueryBits     = NumQueryRegs * RegDataW;
  localparam int unsigned ScoreW        = 13;
  localparam int unsigned RegIdxW       = 3;
  localparam int unsigned RegAddrLsb    = 3;
  localparam int unsigned PAddrW        = RegIdxW + RegAddrLsb;

  localparam logic [ScoreW-1:0] ScoreMax       = {ScoreW{1'b1}};
  localparam logic [ScoreW-1:0] StepWeight     = ScoreW'(10);
  localparam logic [ScoreW-1:0] SubstringBonus = ScoreW'(100);
  localparam logic [QLenW-1:0]  MaxLen         = QLenW'(MaxQueryChars);

  typedef enum logic [RegIdxW-1:0] {
    RegQueryLo    = 3'd0,
    RegQueryMidLo = 3'd1,
    RegQueryMidHi = 3'd2,
    RegQueryHi    = 3'd3,
    RegQueryLen   = 3'd4
  } reg_idx_e;

  // ASCII upper case to lower case, all other codes unchanged
  function automatic logic [CharW-1:0] fold_char(input logic [CharW-1:0] c);
    logic [CharW-1:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

  function automatic logic [ScoreW-1:0] sat_add(input logic [ScoreW-1:0] a,
                                                input logic [ScoreW-1:0] b);
    logic [ScoreW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ScoreW] ? ScoreMax : s[ScoreW-1:0];
  endfunction

endpackage

/* rtl/fss_channels_if.sv */
// Valid/ready channel interfaces for text characters in and scores out.
// Depends on fss_pkg for field widths.
interface fss_text_if import fss_pkg::*;;
  logic             valid;
  logic             ready;
  logic [CharW-1:0] text_char;
  logic             char_present;
  logic             end_of_text;

  modport source (output valid, text_char, char_present, end_of_text, input ready);
  modport sink   (input valid, text_char, char_present, end_of_text, output ready);
endinterface

interface fss_score_if import fss_pkg::*;;
  logic              valid;
  logic              ready;
  logic [ScoreW-1:0] match_score;
  logic              is_substring;

  modport source (output valid, match_score, is_substring, input ready);
  modport sink   (input valid, match_score, is_substring, output ready);
endinterface

/* rtl/fuzzy_subsequence_scorer.sv */
// Fuzzy subsequence scorer: one text character per cycle, one score per text.
// Flow: a transaction is registered at accept and scored from the input register; the result
// of the item that ends the text is written to the result register once that register is free.
// Throughput: 1 item per cycle; the input stage stalls only on an end-of-text item
// while the result register is full and not taken.
// Reset (rst_ni, async, low): clears all query registers and the per-text state.
module fuzzy_subsequence_scorer import fss_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  fss_text_if.sink            text_i,
  fss_score_if.source         score_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PAddrW-1:0]   paddr,
  input  logic [RegDataW-1:0] pwdata,
  output logic [RegDataW-1:0] prdata,
  output logic                pready
);

  // Configuration registers
  logic [NumQueryRegs-1:0][RegDataW-1:0] query_q;
  logic [QLenW-1:0]                      query_len_q;
  logic                                  cfg_wr;
  reg_idx_e                              cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[PAddrW-1:RegAddrLsb]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      query_q     <= '0;
      query_len_q <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        RegQueryLo:    query_q[0]  <= pwdata;
        RegQueryMidLo: query_q[1]  <= pwdata;
        RegQueryMidHi: query_q[2]  <= pwdata;
        RegQueryHi:    query_q[3]  <= pwdata;
        RegQueryLen:   query_len_q <= pwdata[QLenW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      RegQueryLo:    prdata = query_q[0];
      RegQueryMidLo: prdata = query_q[1];
      RegQueryMidHi: prdata = query_q[2];
      RegQueryHi:    prdata = query_q[3];
      RegQueryLen:   prdata = RegDataW'(query_len_q);
      default:       prdata = '0;
    endcase
  end

  // Input register
  logic             in_valid_q;
  logic [CharW-1:0] in_char_q;
  logic             in_present_q;
  logic             in_last_q;
  logic             out_free;
  logic             in_advance;
  logic             in_accept;

  logic              out_valid_q;
  logic [ScoreW-1:0] out_score_q;
  logic              out_sub_q;

  assign out_free      = !out_valid_q || score_o.ready;
  assign in_advance    = in_valid_q && (!in_last_q || out_free);
  assign text_i.ready  = !in_valid_q || in_advance;
  assign in_accept     = text_i.valid && text_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (in_advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_char_q    <= text_i.text_char;
      in_present_q <= text_i.char_present;
      in_last_q    <= text_i.end_of_text;
    end
  end

  // Per-text state
  logic [QLenW-1:0]         matched_q, matched_d;
  logic [ScoreW-1:0]        run_score_q, run_score_d;
  logic [MaxQueryChars-1:0] prefix_q, prefix_d;
  logic                     sub_seen_q, sub_seen_d;

  logic [QueryBits-1:0]     query_flat;
  logic [QLenW-1:0]         eff_len;
  logic [QIdxW-1:0]         last_idx;
  logic [CharW-1:0]         c_fold;
  logic [MaxQueryChars-1:0] char_mask;
  logic [MaxQueryChars-1:0] prefix_hit;
  logic [CharW-1:0]         next_qchar;
  logic                     seq_hit;
  logic [ScoreW-1:0]        step_gain;
  logic                     sub_final;
  logic [ScoreW-1:0]        final_score;

  assign query_flat = query_q;
  assign eff_len    = (query_len_q > MaxLen) ? MaxLen : query_len_q;
  assign last_idx   = QIdxW'(eff_len - QLenW'(1));
  assign c_fold     = fold_char(in_char_q);

  always_comb begin
    for (int k = 0; k < MaxQueryChars; k++) begin
      char_mask[k] = (QLenW'(k) < eff_len) &&
                     (fold_char(query_flat[k*CharW +: CharW]) == c_fold);
    end
  end

  assign prefix_hit = ((prefix_q << 1) | MaxQueryChars'(1)) & char_mask;
  assign next_qchar = fold_char(query_flat[matched_q[QIdxW-1:0]*CharW +: CharW]);
  assign seq_hit    = (matched_q < eff_len) && (next_qchar == c_fold);
  assign step_gain  = ScoreW'(eff_len - matched_q) * StepWeight;

  always_comb begin
    matched_d   = matched_q;
    run_score_d = run_score_q;
    prefix_d    = prefix_q;
    sub_seen_d  = sub_seen_q;
    if (in_present_q) begin
      prefix_d = prefix_hit;
      if (eff_len != '0 && prefix_hit[last_idx]) begin
        sub_seen_d = 1'b1;
      end
      if (seq_hit) begin
        run_score_d = sat_add(run_score_q, step_gain);
        matched_d   = matched_q + QLenW'(1);
      end
    end
  end

  assign sub_final = sub_seen_d || (eff_len == '0);

  always_comb begin
    final_score = '0;
    if (matched_d >= eff_len) begin
      final_score = sub_final ? sat_add(run_score_d, SubstringBonus) : run_score_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      matched_q   <= '0;
      run_score_q <= '0;
      prefix_q    <= '0;
      sub_seen_q  <= 1'b0;
    end else if (in_advance) begin
      if (in_last_q) begin
        // drop the per-text state once the result is taken into the output register
        matched_q   <= '0;
        run_score_q <= '0;
        prefix_q    <= '0;
        sub_seen_q  <= 1'b0;
      end else begin
        matched_q   <= matched_d;
        run_score_q <= run_score_d;
        prefix_q    <= prefix_d;
        sub_seen_q  <= sub_seen_d;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_advance && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (score_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_advance && in_last_q) begin
      out_score_q <= final_score;
      out_sub_q   <= sub_final;
    end
  end

  assign score_o.valid        = out_valid_q;
  assign score_o.match_score  = out_score_q;
  assign score_o.is_substring = out_sub_q;

endmodule

/* rtl/fss_checker.sv */
// Port-level checker for the fuzzy subsequence scorer, attached by bind.
// Depends on fss_pkg and the top level's channel ports.
module fss_checker import fss_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              in_last_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [ScoreW-1:0] out_score_i,
  input logic              out_sub_i
);

  // Count texts whose end was accepted but whose score is not yet delivered
  logic [2:0] pending_q;
  logic       last_acc;
  logic       out_acc;

  assign last_acc = in_valid_i && in_ready_i && in_last_i;
  assign out_acc  = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + 3'(last_acc) - 3'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_score_i) && $stable(out_sub_i))
    else $error("score changed while stalled");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pending_q != 3'd0)
    else $error("score without an accepted end of text");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 3'd2)
    else $error("more texts in flight than the pipeline holds");

  a_bonus: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_sub_i && out_score_i != '0 |-> out_score_i >= SubstringBonus)
    else $error("substring score lacks its bonus");

endmodule

bind fuzzy_subsequence_scorer fss_checker u_fss_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (text_i.valid),
  .in_ready_i  (text_i.ready),
  .in_last_i   (text_i.end_of_text),
  .out_valid_i (score_o.valid),
  .out_ready_i (score_o.ready),
  .out_score_i (score_o.match_score),
  .out_sub_i   (score_o.is_substring)
);
